>>> rtl/odo_pkg.sv
// Types, constants and helper functions shared by the three-wheel odometry core.
// Depends on nothing; every module of the block imports it.
package odo_pkg;

   localparam int MUL_W       = 34;
   localparam int MUL_DIGIT_W = 4;
   localparam int MUL_DIGITS  = (MUL_W + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
   localparam int MUL_LO_W    = MUL_DIGITS * MUL_DIGIT_W;
   localparam int MUL_HI_W    = MUL_W + MUL_DIGIT_W + 2;
   localparam int PROD_W      = 2 * MUL_W;

   localparam int DIV_NUM_W   = 64;
   localparam int DIV_DEN_W   = 57;

   localparam int CORDIC_W    = 34;
   localparam int ACC_W       = 72;

   localparam logic [1:0] CSR_INCHES_PER_TICK    = 2'd0;
   localparam logic [1:0] CSR_SIDE_WHEEL_SPACING = 2'd1;
   localparam logic [1:0] CSR_BACK_WHEEL_OFFSET  = 2'd2;

   localparam logic [31:0] RESET_INCHES_PER_TICK    = 32'd402628;
   localparam logic [15:0] RESET_SIDE_WHEEL_SPACING = 16'd3520;
   localparam logic [15:0] RESET_BACK_WHEEL_OFFSET  = 16'd1920;

   localparam logic [MUL_W-1:0]           INV_TWO_PI_Q32  = 34'd683565276;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [MUL_W-1:0]    ONE_Q30         = 34'sd1073741824;
   localparam logic [DIV_NUM_W-1:0]       SQ_BIAS         = 64'd3 << 34;
   localparam logic [DIV_DEN_W-1:0]       SQ_DEN          = 57'd6 << 34;

   typedef struct packed {
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
      logic signed [31:0] back_count;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] x_position;
      logic signed [31:0] y_position;
      logic [31:0]        heading_angle;
   } rsp_data_type;

   typedef struct packed {
      logic [1:0]  reg_index;
      logic [31:0] write_data;
   } csr_data_type;

   function automatic logic [29:0] atan_of(input logic [4:0] i);
      logic [29:0] a;
      unique case (i)
         5'd0:  a = 30'd536870912;
         5'd1:  a = 30'd316933406;
         5'd2:  a = 30'd167458907;
         5'd3:  a = 30'd85004756;
         5'd4:  a = 30'd42667331;
         5'd5:  a = 30'd21354465;
         5'd6:  a = 30'd10679838;
         5'd7:  a = 30'd5340245;
         5'd8:  a = 30'd2670163;
         5'd9:  a = 30'd1335087;
         5'd10: a = 30'd667544;
         5'd11: a = 30'd333772;
         5'd12: a = 30'd166886;
         5'd13: a = 30'd83443;
         5'd14: a = 30'd41722;
         5'd15: a = 30'd20861;
         5'd16: a = 30'd10430;
         5'd17: a = 30'd5215;
         5'd18: a = 30'd2608;
         5'd19: a = 30'd1304;
         5'd20: a = 30'd652;
         5'd21: a = 30'd326;
         5'd22: a = 30'd163;
         5'd23: a = 30'd81;
         5'd24: a = 30'd41;
         5'd25: a = 30'd20;
         5'd26: a = 30'd10;
         5'd27: a = 30'd5;
         5'd28: a = 30'd3;
         5'd29: a = 30'd1;
         5'd30: a = 30'd1;
         5'd31: a = 30'd0;
         default: a = 30'd0;
      endcase
      return a;
   endfunction

   // round(v / 2^n), ties away from zero
   function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v,
                                                       input int unsigned n);
      logic [ACC_W-1:0] m;
      logic [ACC_W-1:0] r;
      m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      r = (m + (ACC_W'(1) << (n - 1))) >> n;
      return v[ACC_W-1] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > $signed(ACC_W'(32'h7FFF_FFFF))) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -$signed(ACC_W'(32'h8000_0000))) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/odo_channel_if.sv
// Valid/ready channel carrying one payload word of a type chosen per instance.
// Payload types come from odo_pkg.
interface odo_channel_if #(parameter type data_type = logic);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/odo_mul.sv
// Radix-16 digit-serial signed multiplier, one 4-bit digit of b per cycle.
// Depends on odo_pkg for widths.
module odo_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [odo_pkg::MUL_W-1:0]    a,
   input  logic signed [odo_pkg::MUL_W-1:0]    b,
   output logic                                done,
   output logic signed [odo_pkg::PROD_W-1:0]   product
);
   import odo_pkg::*;

   localparam int ACC_T_W = MUL_HI_W + MUL_LO_W;
   localparam logic [3:0] LAST_DIGIT = 4'(MUL_DIGITS - 1);

   logic                    busy_ff, busy_in;
   logic                    fin_ff, fin_in;
   logic                    done_ff, done_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic [MUL_W-1:0]        ma_ff, ma_in;
   logic [ACC_T_W-1:0]      acc_ff, acc_in;
   logic signed [PROD_W-1:0] product_ff, product_in;

   logic [MUL_W+MUL_DIGIT_W-1:0] part;
   logic [MUL_HI_W-1:0]          sum;
   logic [MUL_W-1:0]             mb;

   always_comb begin
      part = ma_ff * acc_ff[MUL_DIGIT_W-1:0];
      sum  = acc_ff[ACC_T_W-1:MUL_LO_W] + MUL_HI_W'(part);
      mb   = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
      busy_in    = busy_ff;
      fin_in     = 1'b0;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      ma_in      = ma_ff;
      acc_in     = acc_ff;
      product_in = product_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = a[MUL_W-1] ^ b[MUL_W-1];
         ma_in   = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
         acc_in  = ACC_T_W'(mb);
      end else if (busy_ff) begin
         acc_in = {MUL_DIGIT_W'(0), sum, acc_ff[MUL_LO_W-1:MUL_DIGIT_W]};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == LAST_DIGIT) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         product_in = neg_ff ? -$signed(acc_ff[PROD_W-1:0]) : $signed(acc_ff[PROD_W-1:0]);
         done_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      ma_ff      <= ma_in;
      acc_ff     <= acc_in;
      product_ff <= product_in;
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

>>> rtl/odo_div.sv
// Restoring unsigned divider, one quotient bit per cycle, quotient floor(n/d).
// Depends on odo_pkg for widths.
module odo_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [odo_pkg::DIV_NUM_W-1:0]     numer,
   input  logic [odo_pkg::DIV_DEN_W-1:0]     denom,
   output logic                              done,
   output logic [odo_pkg::DIV_NUM_W-1:0]     quotient
);
   import odo_pkg::*;

   localparam logic [5:0] LAST_BIT = 6'(DIV_NUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W+1:0] diff;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      ge      = ~diff[DIV_DEN_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = denom;
         rem_in  = '0;
         quo_in  = numer;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == LAST_BIT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/odo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, binary angle in.
// Depends on odo_pkg for the arctangent table and the start gain.
module odo_cordic #(
   parameter int STEPS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [31:0]                          angle,
   output logic                                 done,
   output logic signed [odo_pkg::CORDIC_W-1:0]  cos_out,
   output logic signed [odo_pkg::CORDIC_W-1:0]  sin_out
);
   import odo_pkg::*;

   localparam int RUN_STEPS = (STEPS > 32) ? 32 : STEPS;
   localparam logic [4:0] LAST_STEP = 5'(RUN_STEPS - 1);

   logic                       busy_ff, busy_in;
   logic                       fin_ff, fin_in;
   logic                       done_ff, done_in;
   logic                       flip_ff, flip_in;
   logic [4:0]                 idx_ff, idx_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;
   logic signed [CORDIC_W-1:0] cos_ff, cos_in;
   logic signed [CORDIC_W-1:0] sin_ff, sin_in;

   logic signed [CORDIC_W-1:0] xs, ys, at;
   logic                       fold;
   logic [31:0]                folded;

   always_comb begin
      xs      = x_ff >>> idx_ff;
      ys      = y_ff >>> idx_ff;
      at      = $signed(CORDIC_W'(atan_of(idx_ff)));
      fold    = angle[31] ^ angle[30];
      folded  = {angle[31] ^ fold, angle[30:0]};
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      flip_in = flip_ff;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (start) begin
         busy_in = 1'b1;
         flip_in = fold;
         idx_in  = '0;
         x_in    = CORDIC_GAIN_Q30;
         y_in    = '0;
         z_in    = {{(CORDIC_W-32){folded[31]}}, folded};
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         idx_in = idx_ff + 5'd1;
         if (idx_ff == LAST_STEP) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         cos_in  = flip_ff ? -x_ff : x_ff;
         sin_in  = flip_ff ? -y_ff : y_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

>>> rtl/three_wheel_odometry_core.sv
// Three-wheel tracking odometry core: sequencer over a digit-serial multiplier,
// a bit-serial divider and an iterative CORDIC. Depends on odo_pkg,
// odo_channel_if, odo_mul, odo_div and odo_cordic.
//
// Usage:
//   req_if carries one request of absolute left, right and back encoder counts.
//   rsp_if returns one response per request: the updated x, y (Q16.16 inches,
//   saturating) and heading (binary angle, wrapping).
//   csr_if writes inches_per_tick (index 0), side_wheel_spacing (1) and
//   back_wheel_offset (2); it is always ready, other indexes are dropped.
// Sequencing:
//   One request at a time. With no turn the response follows three multiplies,
//   a CORDIC run and four multiplies (CORDIC_STEPS defaults to 24). A turn adds
//   three divisions, a second CORDIC run and five or six multiplies. The next
//   request can be taken in the cycle after the response is loaded.
// Reset: pose and previous counts clear to zero, registers take their
//   defaults, no response pending.
// Stall: the response waits in an output register; the next request is
//   accepted meanwhile and its result waits until the response is taken.
module three_wheel_odometry_core #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   odo_channel_if.sink          req_if,
   odo_channel_if.source        rsp_if,
   odo_channel_if.sink          csr_if
);
   import odo_pkg::*;

   typedef enum logic [19:0] {
      ST_IDLE     = 20'd1 << 0,
      ST_DIST     = 20'd1 << 1,
      ST_DIFF     = 20'd1 << 2,
      ST_HB_MUL   = 20'd1 << 3,
      ST_HB_DIV   = 20'd1 << 4,
      ST_HR_DIV   = 20'd1 << 5,
      ST_HALF_COR = 20'd1 << 6,
      ST_SQ_MUL   = 20'd1 << 7,
      ST_SQ_DIV   = 20'd1 << 8,
      ST_SINC_DIV = 20'd1 << 9,
      ST_CR_MUL1  = 20'd1 << 10,
      ST_CR_MUL2  = 20'd1 << 11,
      ST_CB_MUL1  = 20'd1 << 12,
      ST_CB_MUL2  = 20'd1 << 13,
      ST_ROT_COR  = 20'd1 << 14,
      ST_RX_MUL1  = 20'd1 << 15,
      ST_RX_MUL2  = 20'd1 << 16,
      ST_RY_MUL1  = 20'd1 << 17,
      ST_RY_MUL2  = 20'd1 << 18,
      ST_OUT      = 20'd1 << 19
   } state_type;

   state_type state_ff, state_in;
   logic      issued_ff, issued_in;
   logic [1:0] dist_idx_ff, dist_idx_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   logic [31:0]        ipt_ff, ipt_in;
   logic [15:0]        spacing_ff, spacing_in;
   logic [15:0]        offset_ff, offset_in;
   logic [31:0]        prev_ff [3];
   logic [31:0]        prev_in [3];
   logic signed [31:0] pos_x_ff, pos_x_in;
   logic signed [31:0] pos_y_ff, pos_y_in;
   logic [31:0]        head_ff, head_in;

   logic signed [31:0] tick_ff [3];
   logic signed [31:0] tick_in [3];
   logic signed [31:0] dist_ff [3];
   logic signed [31:0] dist_in [3];
   logic               neg_ff, neg_in;
   logic [32:0]        dm_ff, dm_in;
   logic [31:0]        half_ff, half_in;
   logic [DIV_DEN_W-1:0] hm_ff, hm_in;
   logic signed [CORDIC_W-1:0] hs_ff, hs_in;
   logic signed [MUL_W-1:0]    sinc_ff, sinc_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [31:0]         chord_r_ff, chord_r_in;
   logic signed [31:0]         chord_b_ff, chord_b_in;
   logic signed [CORDIC_W-1:0] cos_ff, cos_in;
   logic signed [CORDIC_W-1:0] sin_ff, sin_in;

   logic                        mul_start, mul_done;
   logic signed [MUL_W-1:0]     mul_a, mul_b;
   logic signed [PROD_W-1:0]    mul_p;
   logic signed [ACC_W-1:0]     mul_p72;
   logic                        div_start, div_done;
   logic [DIV_NUM_W-1:0]        div_num, div_quot;
   logic [DIV_DEN_W-1:0]        div_den;
   logic                        cor_start, cor_done;
   logic [31:0]                 cor_angle;
   logic signed [CORDIC_W-1:0]  cor_cos, cor_sin;

   logic signed [31:0] cur [3];
   logic [15:0]        sp;
   logic signed [31:0] tick_sel;
   logic [CORDIC_W-1:0] hs_abs;

   odo_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   odo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_num),
      .denom    (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   assign cur[0]   = req_if.data.left_count;
   assign cur[1]   = req_if.data.right_count;
   assign cur[2]   = req_if.data.back_count;
   assign sp       = (spacing_ff == 16'd0) ? 16'd1 : spacing_ff;
   assign tick_sel = tick_ff[dist_idx_ff];
   assign hs_abs   = hs_ff[CORDIC_W-1] ? CORDIC_W'(-hs_ff) : CORDIC_W'(hs_ff);
   assign mul_p72  = {{(ACC_W-PROD_W){mul_p[PROD_W-1]}}, mul_p};

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // operand selection for the shared units
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_num   = '0;
      div_den   = '0;
      cor_angle = half_ff;
      unique case (state_ff)
         ST_DIST: begin
            mul_a = {{2{tick_sel[31]}}, tick_sel};
            mul_b = {2'b00, ipt_ff};
         end
         ST_HB_MUL: begin
            mul_a = {1'b0, dm_ff};
            mul_b = INV_TWO_PI_Q32;
         end
         ST_HB_DIV: begin
            div_num = acc_ff[DIV_NUM_W-1:0] + DIV_NUM_W'({sp, 8'b0});
            div_den = DIV_DEN_W'({sp, 9'b0});
         end
         ST_HR_DIV: begin
            div_num = DIV_NUM_W'({dm_ff, 23'b0}) + DIV_NUM_W'(sp >> 1);
            div_den = DIV_DEN_W'(sp);
         end
         ST_SQ_MUL: begin
            mul_a = {8'b0, hm_ff[25:0]};
            mul_b = {8'b0, hm_ff[25:0]};
         end
         ST_SQ_DIV: begin
            div_num = acc_ff[DIV_NUM_W-1:0] + SQ_BIAS;
            div_den = SQ_DEN;
         end
         ST_SINC_DIV: begin
            div_num = {hs_abs[31:0], 32'b0} + DIV_NUM_W'(hm_ff >> 1);
            div_den = hm_ff;
         end
         ST_CR_MUL1: begin
            mul_a = {{2{dist_ff[1][31]}}, dist_ff[1]};
            mul_b = sinc_ff;
         end
         ST_CR_MUL2: begin
            mul_a = {18'b0, sp};
            mul_b = hs_ff;
         end
         ST_CB_MUL1: begin
            mul_a = {{2{dist_ff[2][31]}}, dist_ff[2]};
            mul_b = sinc_ff;
         end
         ST_CB_MUL2: begin
            mul_a = {18'b0, offset_ff};
            mul_b = hs_ff;
         end
         ST_ROT_COR: cor_angle = head_ff + half_ff;
         ST_RX_MUL1: begin
            mul_a = {{2{chord_r_ff[31]}}, chord_r_ff};
            mul_b = sin_ff;
         end
         ST_RX_MUL2: begin
            mul_a = {{2{chord_b_ff[31]}}, chord_b_ff};
            mul_b = cos_ff;
         end
         ST_RY_MUL1: begin
            mul_a = {{2{chord_r_ff[31]}}, chord_r_ff};
            mul_b = cos_ff;
         end
         ST_RY_MUL2: begin
            mul_a = {{2{chord_b_ff[31]}}, chord_b_ff};
            mul_b = sin_ff;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      logic signed [32:0]      diff;
      logic signed [ACC_W-1:0] sum;
      logic [MUL_W-1:0]        q34;
      logic [31:0]             q32;

      diff = {dist_ff[0][31], dist_ff[0]} - {dist_ff[1][31], dist_ff[1]};
      sum  = '0;
      q34  = div_quot[MUL_W-1:0];
      q32  = div_quot[31:0];

      state_in     = state_ff;
      issued_in    = issued_ff;
      dist_idx_in  = dist_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ipt_in       = ipt_ff;
      spacing_in   = spacing_ff;
      offset_in    = offset_ff;
      prev_in      = prev_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_in      = head_ff;
      tick_in      = tick_ff;
      dist_in      = dist_ff;
      neg_in       = neg_ff;
      dm_in        = dm_ff;
      half_in      = half_ff;
      hm_in        = hm_ff;
      hs_in        = hs_ff;
      sinc_in      = sinc_ff;
      acc_in       = acc_ff;
      chord_r_in   = chord_r_ff;
      chord_b_in   = chord_b_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      cor_start    = 1'b0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               for (int k = 0; k < 3; k++) begin
                  tick_in[k] = cur[k] - prev_ff[k];
                  prev_in[k] = cur[k];
               end
               dist_idx_in = '0;
               state_in    = ST_DIST;
            end
         end
         ST_DIST: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               dist_in[dist_idx_ff] = sat32(rnd_shift(mul_p72, 8));
               if (dist_idx_ff == 2'd2) begin
                  state_in = ST_DIFF;
               end else begin
                  dist_idx_in = dist_idx_ff + 2'd1;
               end
            end
         end
         ST_DIFF: begin
            if (diff == 33'sd0) begin
               chord_r_in = dist_ff[1];
               chord_b_in = dist_ff[2];
               half_in    = '0;
               state_in   = ST_ROT_COR;
            end else begin
               neg_in   = diff[32];
               dm_in    = diff[32] ? 33'(-diff) : 33'(diff);
               state_in = ST_HB_MUL;
            end
         end
         ST_HB_MUL: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               acc_in    = mul_p72;
               state_in  = ST_HB_DIV;
            end
         end
         ST_HB_DIV: begin
            div_start = !issued_ff;
            issued_in = 1'b1;
            if (div_done) begin
               issued_in = 1'b0;
               half_in   = neg_ff ? -q32 : q32;
               state_in  = ST_HR_DIV;
            end
         end
         ST_HR_DIV: begin
            div_start = !issued_ff;
            issued_in = 1'b1;
            if (div_done) begin
               issued_in = 1'b0;
               hm_in     = div_quot[DIV_DEN_W-1:0];
               state_in  = ST_HALF_COR;
            end
         end
         ST_HALF_COR: begin
            cor_start = !issued_ff;
            issued_in = 1'b1;
            if (cor_done) begin
               issued_in = 1'b0;
               hs_in     = cor_sin;
               state_in  = (hm_ff[DIV_DEN_W-1:26] == '0) ? ST_SQ_MUL : ST_SINC_DIV;
            end
         end
         ST_SQ_MUL: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               acc_in    = mul_p72;
               state_in  = ST_SQ_DIV;
            end
         end
         ST_SQ_DIV: begin
            div_start = !issued_ff;
            issued_in = 1'b1;
            if (div_done) begin
               issued_in = 1'b0;
               sinc_in   = ONE_Q30 - $signed(q34);
               state_in  = ST_CR_MUL1;
            end
         end
         ST_SINC_DIV: begin
            div_start = !issued_ff;
            issued_in = 1'b1;
            if (div_done) begin
               issued_in = 1'b0;
               sinc_in   = (hs_ff[CORDIC_W-1] ^ neg_ff) ? -$signed(q34) : $signed(q34);
               state_in  = ST_CR_MUL1;
            end
         end
         ST_CR_MUL1: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               acc_in    = rnd_shift(mul_p72, 30);
               state_in  = ST_CR_MUL2;
            end
         end
         ST_CR_MUL2: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in  = 1'b0;
               chord_r_in = sat32(acc_ff + rnd_shift(mul_p72, 22));
               state_in   = ST_CB_MUL1;
            end
         end
         ST_CB_MUL1: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               acc_in    = rnd_shift(mul_p72, 30);
               state_in  = ST_CB_MUL2;
            end
         end
         ST_CB_MUL2: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in  = 1'b0;
               chord_b_in = sat32(acc_ff + rnd_shift(mul_p72, 21));
               state_in   = ST_ROT_COR;
            end
         end
         ST_ROT_COR: begin
            cor_start = !issued_ff;
            issued_in = 1'b1;
            if (cor_done) begin
               issued_in = 1'b0;
               cos_in    = cor_cos;
               sin_in    = cor_sin;
               state_in  = ST_RX_MUL1;
            end
         end
         ST_RX_MUL1: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               acc_in    = mul_p72;
               state_in  = ST_RX_MUL2;
            end
         end
         ST_RX_MUL2: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               sum       = rnd_shift(acc_ff + mul_p72, 30);
               pos_x_in  = sat32({{(ACC_W-32){pos_x_ff[31]}}, pos_x_ff} + sum);
               state_in  = ST_RY_MUL1;
            end
         end
         ST_RY_MUL1: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               acc_in    = mul_p72;
               state_in  = ST_RY_MUL2;
            end
         end
         ST_RY_MUL2: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               sum       = rnd_shift(acc_ff - mul_p72, 30);
               pos_y_in  = sat32({{(ACC_W-32){pos_y_ff[31]}}, pos_y_ff} + sum);
               head_in   = head_ff + {half_ff[30:0], 1'b0};
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.x_position    = pos_x_ff;
               rsp_data_in.y_position    = pos_y_ff;
               rsp_data_in.heading_angle = head_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_if.valid) begin
         unique case (csr_if.data.reg_index)
            CSR_INCHES_PER_TICK:    ipt_in     = csr_if.data.write_data;
            CSR_SIDE_WHEEL_SPACING: spacing_in = csr_if.data.write_data[15:0];
            CSR_BACK_WHEEL_OFFSET:  offset_in  = csr_if.data.write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         dist_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         ipt_ff       <= RESET_INCHES_PER_TICK;
         spacing_ff   <= RESET_SIDE_WHEEL_SPACING;
         offset_ff    <= RESET_BACK_WHEEL_OFFSET;
         prev_ff      <= '{default: '0};
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         dist_idx_ff  <= dist_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         ipt_ff       <= ipt_in;
         spacing_ff   <= spacing_in;
         offset_ff    <= offset_in;
         prev_ff      <= prev_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      tick_ff     <= tick_in;
      dist_ff     <= dist_in;
      neg_ff      <= neg_in;
      dm_ff       <= dm_in;
      half_ff     <= half_in;
      hm_ff       <= hm_in;
      hs_ff       <= hs_in;
      sinc_ff     <= sinc_in;
      acc_ff      <= acc_in;
      chord_r_ff  <= chord_r_in;
      chord_b_ff  <= chord_b_in;
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
   end

endmodule
